### rtl/lprl_pkg.sv
`default_nettype none

package lprl_pkg;

   // Table depth, one chain cell per route slot
   localparam int unsigned ENTRIES = 16;

   // Width of a cell's slot number, and the common width for comparing it
   // against the 4-bit entry index of a write
   localparam int unsigned SLOT_ID_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned INDEX_W = 4;
   localparam int unsigned CMP_W = (SLOT_ID_W > INDEX_W) ? SLOT_ID_W : INDEX_W;

   localparam logic [31:0] ADDR_ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [5:0] ADDR_BITS = 6'd32;

   // Request codes
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // One request as it travels down the chain
   typedef struct packed {
      logic kind;
      logic [INDEX_W-1:0] entry_index;
      logic [31:0] address;
      logic [5:0] prefix_len;
      logic [31:0] next_hop;
      logic [3:0] iface;
      logic [15:0] cost;
      logic entry_valid;
   } req_item_type;

   // Best route found so far, all zero when none
   typedef struct packed {
      logic found;
      logic [31:0] next_hop;
      logic [3:0] iface;
      logic [31:0] network;
      logic [5:0] prefix;
      logic [15:0] cost;
   } route_type;

   // Contents of one chain stage
   typedef struct packed {
      logic valid;
      req_item_type item;
      route_type best;
   } stage_type;

endpackage

`default_nettype wire

### rtl/longest_prefix_route_lookup.sv
`default_nettype none

// IPv4 longest-prefix route lookup over a table of lprl_pkg::ENTRIES slots.
// Every request, write or lookup, walks a chain of one cell per slot, one
// cell a cycle while the chain moves, and one request can enter every cycle
// unless req_stall is raised. Writes and lookups keep their order: a lookup
// sees every write accepted before it. The last cell's register is the
// result register; while a result is held by rsp_stall the whole chain
// waits, and req_stall is raised. Each request gives exactly one result;
// writes and unmatched lookups return found low and all fields zero. The
// table is empty after reset.
module longest_prefix_route_lookup (
   input wire logic clock,
   input wire logic reset,

   input wire logic req_valid,
   output logic req_stall,
   input wire logic req_type,
   input wire logic [3:0] req_entry_index,
   input wire logic [31:0] req_address,
   input wire logic [5:0] req_prefix_len,
   input wire logic [31:0] req_next_hop,
   input wire logic [3:0] req_iface,
   input wire logic [15:0] req_cost,
   input wire logic req_entry_valid,

   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic rsp_found,
   output logic [31:0] rsp_route_next_hop,
   output logic [3:0] rsp_route_iface,
   output logic [31:0] rsp_route_network,
   output logic [5:0] rsp_route_prefix,
   output logic [15:0] rsp_route_cost
);

   localparam int unsigned Entries = lprl_pkg::ENTRIES;
   localparam int unsigned IdW = lprl_pkg::SLOT_ID_W;

   lprl_pkg::stage_type chain [Entries+1];
   logic advance;

   // Chain moves unless a finished result is being held
   assign advance = !chain[Entries].valid || !rsp_stall;
   assign req_stall = !advance;

   // Chain entry: the request with an empty best route
   always_comb begin
      chain[0].valid = req_valid;
      chain[0].item.kind = req_type;
      chain[0].item.entry_index = req_entry_index;
      chain[0].item.address = req_address;
      chain[0].item.prefix_len = req_prefix_len;
      chain[0].item.next_hop = req_next_hop;
      chain[0].item.iface = req_iface;
      chain[0].item.cost = req_cost;
      chain[0].item.entry_valid = req_entry_valid;
      chain[0].best = '0;
   end

   for (genvar k = 0; k < Entries; k++) begin : g_cell
      lprl_cell u_cell (
         .clock (clock),
         .reset (reset),
         .advance (advance),
         .cell_id (IdW'(k)),
         .stage_in (chain[k]),
         .stage_out (chain[k+1])
      );
   end

   // Result port
   assign rsp_valid = chain[Entries].valid;
   assign rsp_found = chain[Entries].best.found;
   assign rsp_route_next_hop = chain[Entries].best.next_hop;
   assign rsp_route_iface = chain[Entries].best.iface;
   assign rsp_route_network = chain[Entries].best.network;
   assign rsp_route_prefix = chain[Entries].best.prefix;
   assign rsp_route_cost = chain[Entries].best.cost;

   // No result straight after a reset cycle
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Without a match every route field is zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |->
         rsp_route_next_hop == 32'd0 && rsp_route_network == 32'd0 &&
         rsp_route_iface == 4'd0 && rsp_route_prefix == 6'd0 && rsp_route_cost == 16'd0)
      else $error("route fields set without a match");

   // A found route never has a prefix above the address width
   a_found_prefix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_route_prefix <= lprl_pkg::ADDR_BITS)
      else $error("matched route with prefix above 32");

   // A write never reports a route
   a_write_no_route: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && chain[Entries].item.kind == lprl_pkg::REQ_WRITE |-> !rsp_found)
      else $error("write request returned a route");

endmodule

`default_nettype wire

### rtl/lprl_cell.sv
`default_nettype none

// One route slot of the chain. It takes the write addressed to it, and for a
// passing lookup it replaces the carried best route when its own is better.
module lprl_cell (
   input wire logic clock,
   input wire logic reset,
   input wire logic advance,
   input wire logic [lprl_pkg::SLOT_ID_W-1:0] cell_id,
   input wire lprl_pkg::stage_type stage_in,
   output lprl_pkg::stage_type stage_out
);

   localparam int unsigned CmpW = lprl_pkg::CMP_W;

   // Slot contents
   logic slot_valid_ff;
   logic [31:0] slot_network_ff;
   logic [5:0] slot_prefix_ff;
   logic [31:0] slot_next_hop_ff;
   logic [3:0] slot_iface_ff;
   logic [15:0] slot_cost_ff;

   logic stage_valid_ff;
   lprl_pkg::req_item_type item_ff;
   lprl_pkg::route_type best_ff, best_in;

   logic write_here;
   logic [31:0] mask;
   logic hit;
   logic better;

   // Write addressed to this slot
   assign write_here = stage_in.valid && (stage_in.item.kind == lprl_pkg::REQ_WRITE) &&
                       (CmpW'(stage_in.item.entry_index) == CmpW'(cell_id));

   // Prefix compare; a length of zero gives an empty mask and matches all
   assign mask = ~(lprl_pkg::ADDR_ALL_ONES >> slot_prefix_ff);
   assign hit = slot_valid_ff && (slot_prefix_ff <= lprl_pkg::ADDR_BITS) &&
                ((stage_in.item.address & mask) == (slot_network_ff & mask));

   // Strictly better only, so the earlier slot keeps a full tie
   assign better = !stage_in.best.found ||
                   (slot_prefix_ff > stage_in.best.prefix) ||
                   ((slot_prefix_ff == stage_in.best.prefix) &&
                    (slot_cost_ff < stage_in.best.cost));

   always_comb begin
      best_in = stage_in.best;
      if (stage_in.item.kind == lprl_pkg::REQ_LOOKUP && hit && better) begin
         best_in.found = 1'b1;
         best_in.next_hop = slot_next_hop_ff;
         best_in.iface = slot_iface_ff;
         best_in.network = slot_network_ff;
         best_in.prefix = slot_prefix_ff;
         best_in.cost = slot_cost_ff;
      end
   end

   // Slot valid mark
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else if (advance && write_here) begin
         slot_valid_ff <= stage_in.item.entry_valid;
      end
   end

   // Slot data, written by every write to this slot, also one that removes the route
   always_ff @(posedge clock) begin
      if (advance && write_here) begin
         slot_network_ff <= stage_in.item.address;
         slot_prefix_ff <= stage_in.item.prefix_len;
         slot_next_hop_ff <= stage_in.item.next_hop;
         slot_iface_ff <= stage_in.item.iface;
         slot_cost_ff <= stage_in.item.cost;
      end
   end

   // Stage register towards the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (advance) begin
         stage_valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= stage_in.item;
         best_ff <= best_in;
      end
   end

   assign stage_out.valid = stage_valid_ff;
   assign stage_out.item = item_ff;
   assign stage_out.best = best_ff;

endmodule

`default_nettype wire
